// ----- src/crs_pkg.sv -----
// Shared types and constants for the colour region steering block.
// No dependencies; imported by every module of the block.
`default_nettype none

package crs_pkg;

	localparam int HIT_W      = 23;
	localparam int TOTAL_W    = 25;
	localparam int FW_W       = 13;
	localparam int COLOUR_W   = 24;
	localparam int SPEED_W    = 15;
	localparam int TURN_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int OUT_DATA_W = 40;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COLOUR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_SPEED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE     = 3'd5;

	localparam int                    RST_FRAME_WIDTH   = 640;
	localparam logic [COLOUR_W-1:0]   RST_TARGET_COLOUR = 24'hFFFF00;
	localparam logic [HIT_W-1:0]      RST_LOW_LIMIT     = 23'd100;
	localparam logic [HIT_W-1:0]      RST_HIGH_LIMIT    = 23'd60000;
	localparam logic [SPEED_W-1:0]    RST_FORWARD_SPEED = 15'd2048;
	localparam logic [SPEED_W-1:0]    RST_TURN_RATE     = 15'd1229;

	typedef enum logic [1:0] {
		DIR_STOP  = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_AHEAD = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		REG_NONE   = 2'd0,
		REG_LEFT   = 2'd1,
		REG_MIDDLE = 2'd2,
		REG_RIGHT  = 2'd3
	} region_t;

	typedef struct packed {
		region_t region;
		logic    last;
	} pix_code_t;

	typedef struct packed {
		logic [HIT_W-1:0]   low_limit;
		logic [HIT_W-1:0]   high_limit;
		logic [SPEED_W-1:0] forward_speed;
		logic [SPEED_W-1:0] turn_rate;
	} back_cfg_t;

endpackage

`default_nettype wire

// ----- src/color_region_steering.sv -----
// Colour region steering: one RGB pixel per clock in while the queue has room, a
// speed/turn command out on each frame end whose command differs from the previous
// one. The front end classifies a pixel in the cycle it is accepted; a four-entry
// queue decouples it from the back end, which counts and decides. Sustained rate is
// one pixel per clock, set by the column counter and region compare; a command passes
// through the queue, the snapshot and decision registers and the output register.
// Only a frame-end pixel waits on a stalled output, and the queue keeps the input side
// flowing meanwhile. Configuration writes are always ready and take effect at once.
`default_nettype none

module color_region_steering #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [23:0]                      s_tdata,   // red, green, blue
	input  wire logic                             s_tlast,   // frame_end
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [crs_pkg::OUT_DATA_W-1:0]        m_tdata,   // linear_speed, angular_rate,
	                                                         // direction, zero pad
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [crs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [crs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import crs_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = CW + 1;
	localparam int XW = (EW > FW_W) ? EW : FW_W;
	localparam int K  = EW + 1;
	localparam logic [K:0] RECIP = (K+1)'(((64'd1 << K) + 64'd2) / 64'd3);
	localparam int RST_W     = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
	localparam int RST_THIRD = RST_W / 3;

	logic [EW-1:0]       width_q, third_q, bound_q;
	logic [COLOUR_W-1:0] target_q;
	back_cfg_t           back_cfg_q;

	logic [XW-1:0]       fw_x, w_clamp;
	logic [EW-1:0]       w_new, third_new;
	logic [EW+K:0]       prod;
	logic                cfg_we;

	pix_code_t           push_data, pop_data;
	logic                push, pop, full, empty;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// width clamp and divide by three via reciprocal
	always_comb begin
		fw_x = XW'(cfg_data[FW_W-1:0]);
		if (fw_x < XW'(3)) begin
			w_clamp = XW'(3);
		end else if (fw_x > XW'(MAX_WIDTH)) begin
			w_clamp = XW'(MAX_WIDTH);
		end else begin
			w_clamp = fw_x;
		end
	end

	assign w_new     = EW'(w_clamp);
	assign prod      = (EW+K+1)'(w_new) * (EW+K+1)'(RECIP);
	assign third_new = EW'(prod >> K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q                  <= EW'(RST_W);
			third_q                  <= EW'(RST_THIRD);
			bound_q                  <= EW'(RST_W - RST_THIRD);
			target_q                 <= RST_TARGET_COLOUR;
			back_cfg_q.low_limit     <= RST_LOW_LIMIT;
			back_cfg_q.high_limit    <= RST_HIGH_LIMIT;
			back_cfg_q.forward_speed <= RST_FORWARD_SPEED;
			back_cfg_q.turn_rate     <= RST_TURN_RATE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH: begin
					width_q <= w_new;
					third_q <= third_new;
					bound_q <= w_new - third_new;
				end
				CFG_TARGET_COLOUR: target_q <= cfg_data[COLOUR_W-1:0];
				CFG_LOW_LIMIT:     back_cfg_q.low_limit <= cfg_data[HIT_W-1:0];
				CFG_HIGH_LIMIT:    back_cfg_q.high_limit <= cfg_data[HIT_W-1:0];
				CFG_FORWARD_SPEED: back_cfg_q.forward_speed <= cfg_data[SPEED_W-1:0];
				CFG_TURN_RATE:     back_cfg_q.turn_rate <= cfg_data[SPEED_W-1:0];
				default:           ;
			endcase
		end
	end

	crs_front #(
		.CW(CW),
		.EW(EW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.width    (width_q),
		.third    (third_q),
		.bound    (bound_q),
		.target   (target_q),
		.q_push   (push),
		.q_data   (push_data),
		.q_full   (full)
	);

	crs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	crs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (pop_data),
		.q_empty  (empty),
		.q_pop    (pop),
		.cfg      (back_cfg_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ----- src/crs_front.sv -----
// Front end: accepts pixels, tracks the column and classifies each pixel by region.
// Depends on crs_pkg; feeds the classification queue.
`default_nettype none

module crs_front #(
	parameter int CW = 12,
	parameter int EW = 13
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [23:0]                   s_tdata,   // red, green, blue
	input  wire logic                          s_tlast,   // frame_end
	input  wire logic [EW-1:0]                 width,
	input  wire logic [EW-1:0]                 third,
	input  wire logic [EW-1:0]                 bound,
	input  wire logic [crs_pkg::COLOUR_W-1:0]  target,
	output logic                               q_push,
	output crs_pkg::pix_code_t                 q_data,
	input  wire logic                          q_full
);
	import crs_pkg::*;

	logic [CW-1:0]       column_q;
	logic [EW-1:0]       col_x;
	logic [EW-1:0]       col_inc;
	logic [COLOUR_W-1:0] pixel;
	logic                accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept;

	assign pixel   = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
	assign col_x   = EW'(column_q);
	assign col_inc = col_x + EW'(1);

	always_comb begin
		q_data.last = s_tlast;
		if (pixel != target) begin
			q_data.region = REG_NONE;
		end else if (col_x < third) begin
			q_data.region = REG_LEFT;
		end else if (col_x < bound) begin
			q_data.region = REG_MIDDLE;
		end else begin
			q_data.region = REG_RIGHT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
		end else if (accept) begin
			if (s_tlast || (col_inc >= width)) begin
				column_q <= '0;
			end else begin
				column_q <= col_inc[CW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/crs_fifo.sv -----
// Short queue of classified pixels between the front and back ends.
// Depends on crs_pkg for the entry type and depth.
`default_nettype none

module crs_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire crs_pkg::pix_code_t push_data,
	output logic               full,
	input  wire logic          pop,
	output crs_pkg::pix_code_t pop_data,
	output logic               empty
);
	import crs_pkg::*;

	pix_code_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/crs_back.sv -----
// Back end: region counters, frame decision pipeline and output register.
// Depends on crs_pkg; drains the classification queue.
`default_nettype none

module crs_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire crs_pkg::pix_code_t              q_data,
	input  wire logic                            q_empty,
	output logic                                 q_pop,
	input  wire crs_pkg::back_cfg_t              cfg,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [crs_pkg::OUT_DATA_W-1:0]       m_tdata   // linear_speed, angular_rate, direction
);
	import crs_pkg::*;

	logic [HIT_W-1:0]   left_q, middle_q, right_q;
	logic [HIT_W-1:0]   left_n, middle_n, right_n;
	logic [HIT_W-1:0]   left_s1, middle_s1, right_s1;
	logic               valid_s1;
	logic               valid_s2, stop_s2, left_win_s2, mid_win_s2;
	logic [TOTAL_W-1:0] total;
	logic               en;

	logic               out_valid_q;
	logic [SPEED_W-1:0] speed_q, prev_speed_q, speed_d;
	logic [TURN_W-1:0]  turn_q, prev_turn_q, turn_d;
	dir_t               dir_q, dir_d;
	logic               differs;

	assign en    = !out_valid_q || m_tready;
	assign q_pop = !q_empty && (en || !q_data.last);

	always_comb begin
		left_n   = left_q;
		middle_n = middle_q;
		right_n  = right_q;
		case (q_data.region)
			REG_LEFT:   if (left_q != '1) left_n = left_q + HIT_W'(1);
			REG_MIDDLE: if (middle_q != '1) middle_n = middle_q + HIT_W'(1);
			REG_RIGHT:  if (right_q != '1) right_n = right_q + HIT_W'(1);
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			middle_q <= '0;
			right_q  <= '0;
		end else if (q_pop) begin
			if (q_data.last) begin
				left_q   <= '0;
				middle_q <= '0;
				right_q  <= '0;
			end else begin
				left_q   <= left_n;
				middle_q <= middle_n;
				right_q  <= right_n;
			end
		end
	end

	// frame snapshot; a frame-end pop only happens with en high
	always_ff @(posedge clk) begin
		if (q_pop && q_data.last) begin
			left_s1   <= left_n;
			middle_s1 <= middle_n;
			right_s1  <= right_n;
		end
	end

	assign total = TOTAL_W'(left_s1) + TOTAL_W'(middle_s1) + TOTAL_W'(right_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			stop_s2     <= (total > TOTAL_W'(cfg.high_limit)) ||
			               (total < TOTAL_W'(cfg.low_limit));
			left_win_s2 <= (left_s1 >= middle_s1) && (left_s1 >= right_s1);
			mid_win_s2  <= (middle_s1 > left_s1) && (middle_s1 >= right_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= q_pop && q_data.last;
			valid_s2 <= valid_s1;
		end
	end

	always_comb begin
		if (stop_s2) begin
			dir_d   = DIR_STOP;
			speed_d = '0;
			turn_d  = '0;
		end else if (left_win_s2) begin
			dir_d   = DIR_LEFT;
			speed_d = cfg.forward_speed;
			turn_d  = {1'b0, cfg.turn_rate};
		end else if (mid_win_s2) begin
			dir_d   = DIR_AHEAD;
			speed_d = cfg.forward_speed;
			turn_d  = '0;
		end else begin
			dir_d   = DIR_RIGHT;
			speed_d = cfg.forward_speed;
			turn_d  = TURN_W'(0) - {1'b0, cfg.turn_rate};
		end
	end

	assign differs = (speed_d != prev_speed_q) || (turn_d != prev_turn_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			prev_speed_q <= '0;
			prev_turn_q  <= '0;
		end else if (en) begin
			out_valid_q <= valid_s2 && differs;
			if (valid_s2 && differs) begin
				prev_speed_q <= speed_d;
				prev_turn_q  <= turn_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2 && differs) begin
			speed_q <= speed_d;
			turn_q  <= turn_d;
			dir_q   <= dir_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, dir_q, turn_q, speed_q};

endmodule

`default_nettype wire

// ----- src/crs_checker.sv -----
// Port-level checks on the steering command stream, bound to the top level.
// Depends on crs_pkg for the direction codes.
`default_nettype none

module crs_port_checks (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [crs_pkg::OUT_DATA_W-1:0] m_tdata
);
	import crs_pkg::*;

	// stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[32:31] == DIR_STOP) |-> (m_tdata[30:0] == '0))
		else $error("stop command with non-zero speed or turn");

	a_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[32:31] == DIR_AHEAD) |-> (m_tdata[30:15] == '0))
		else $error("ahead command with non-zero turn");

	a_left: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[32:31] == DIR_LEFT) |-> !m_tdata[30])
		else $error("left command with negative turn");

	a_right: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[32:31] == DIR_RIGHT) |-> (m_tdata[30] || (m_tdata[30:15] == '0)))
		else $error("right command with positive turn");

endmodule

bind color_region_steering crs_port_checks u_crs_checker (.*);

`default_nettype wire

// ----- dv/crs_checker.sv -----
// Scoreboard for color_region_steering: follows configuration and pixel transactions,
// predicts each steering command and compares it with the output stream.
// Depends on crs_pkg for widths, register indexes and the direction codes.
module crs_checker
	import crs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [23:0]           s_tdata,   // red, green, blue
	input  logic                  s_tlast,   // frame_end
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // linear_speed, angular_rate, direction, pad
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int               WIDTH_CAP = 4096;
	localparam logic [HIT_W-1:0] HIT_CEIL  = '1;

	typedef struct packed {
		dir_t               direction;
		logic [TURN_W-1:0]  angular_rate;
		logic [SPEED_W-1:0] linear_speed;
	} steer_cmd_t;

	logic [FW_W-1:0]     width_reg;
	logic [COLOUR_W-1:0] colour_reg;
	logic [HIT_W-1:0]    low_reg;
	logic [HIT_W-1:0]    high_reg;
	logic [SPEED_W-1:0]  speed_reg;
	logic [SPEED_W-1:0]  rate_reg;

	logic [11:0]         column;
	logic [HIT_W-1:0]    left_hits;
	logic [HIT_W-1:0]    middle_hits;
	logic [HIT_W-1:0]    right_hits;
	logic [15:0]         last_speed;
	logic [15:0]         last_turn;

	steer_cmd_t          pending_commands[$];
	int                  fails   = 0;
	int                  waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	function automatic logic [HIT_W-1:0] bump(input logic [HIT_W-1:0] v);
		return (v == HIT_CEIL) ? v : v + 1'b1;
	endfunction

	task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
		$display("mismatch: %s got %0h expected %0h", what, got, want);
		fails++;
	endtask

	task automatic count_and_steer(input logic [23:0] data, input logic last);
		int                  w;
		int                  third;
		int                  col;
		logic [COLOUR_W-1:0] rgb;
		logic [TOTAL_W-1:0]  total;
		steer_cmd_t          cmd;
		w = int'(width_reg);
		if (w < 3)
			w = 3;
		else if (w > WIDTH_CAP)
			w = WIDTH_CAP;
		third = w / 3;
		col   = int'(column);
		rgb   = {data[7:0], data[15:8], data[23:16]};
		if (rgb == colour_reg) begin
			if (col < third)
				left_hits = bump(left_hits);
			else if (col < w - third)
				middle_hits = bump(middle_hits);
			else
				right_hits = bump(right_hits);
		end
		column = (col + 1 >= w) ? '0 : 12'(col + 1);
		if (!last)
			return;

		total = TOTAL_W'(left_hits) + TOTAL_W'(middle_hits) + TOTAL_W'(right_hits);
		cmd.linear_speed = speed_reg;
		if (total > TOTAL_W'(high_reg) || total < TOTAL_W'(low_reg)) begin
			cmd.linear_speed = '0;
			cmd.angular_rate = '0;
			cmd.direction    = DIR_STOP;
		end else if (left_hits >= middle_hits && left_hits >= right_hits) begin
			cmd.angular_rate = {1'b0, rate_reg};
			cmd.direction    = DIR_LEFT;
		end else if (middle_hits > left_hits && middle_hits >= right_hits) begin
			cmd.angular_rate = '0;
			cmd.direction    = DIR_AHEAD;
		end else begin
			cmd.angular_rate = TURN_W'(0) - {1'b0, rate_reg};
			cmd.direction    = DIR_RIGHT;
		end

		column      = '0;
		left_hits   = '0;
		middle_hits = '0;
		right_hits  = '0;

		// repeated command is swallowed
		if ({1'b0, cmd.linear_speed} == last_speed && cmd.angular_rate == last_turn)
			return;
		last_speed = {1'b0, cmd.linear_speed};
		last_turn  = cmd.angular_rate;
		pending_commands.push_back(cmd);
	endtask

	task automatic check_command(input logic [OUT_DATA_W-1:0] data);
		steer_cmd_t want;
		if (pending_commands.size() == 0) begin
			report("command with none outstanding", data, '0);
			return;
		end
		want = pending_commands.pop_front();
		if (data[SPEED_W-1:0] !== want.linear_speed)
			report("linear_speed", data[SPEED_W-1:0], want.linear_speed);
		if (data[SPEED_W+TURN_W-1:SPEED_W] !== want.angular_rate)
			report("angular_rate", data[SPEED_W+TURN_W-1:SPEED_W], want.angular_rate);
		if (data[SPEED_W+TURN_W+1:SPEED_W+TURN_W] !== want.direction)
			report("direction", data[SPEED_W+TURN_W+1:SPEED_W+TURN_W], want.direction);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg   = FW_W'(RST_FRAME_WIDTH);
			colour_reg  = RST_TARGET_COLOUR;
			low_reg     = RST_LOW_LIMIT;
			high_reg    = RST_HIGH_LIMIT;
			speed_reg   = RST_FORWARD_SPEED;
			rate_reg    = RST_TURN_RATE;
			column      = '0;
			left_hits   = '0;
			middle_hits = '0;
			right_hits  = '0;
			last_speed  = '0;
			last_turn   = '0;
			pending_commands.delete();
			waiting     = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:   width_reg  = cfg_data[FW_W-1:0];
					CFG_TARGET_COLOUR: colour_reg = cfg_data[COLOUR_W-1:0];
					CFG_LOW_LIMIT:     low_reg    = cfg_data[HIT_W-1:0];
					CFG_HIGH_LIMIT:    high_reg   = cfg_data[HIT_W-1:0];
					CFG_FORWARD_SPEED: speed_reg  = cfg_data[SPEED_W-1:0];
					CFG_TURN_RATE:     rate_reg   = cfg_data[SPEED_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				count_and_steer(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_command(m_tdata);
			waiting = pending_commands.size();
		end
	end

endmodule

// ----- dv/color_region_steering_tb.sv -----
// Top of the color_region_steering testbench: clock, reset, pixel and register stimulus,
// output back-pressure and the verdict. Checking is done by crs_checker.
// Depends on crs_pkg, crs_checker and the block itself.
module color_region_steering_tb;
	import crs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	localparam int IDLE_PCT     = 38;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 12;
	localparam int PHASE_PIXELS = 55;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;   // red, green, blue
	logic                  s_tlast;   // frame_end
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // linear_speed, angular_rate, direction, pad
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;

	bit                    steady   = 1'b0;
	bit                    hold_req = 1'b0;
	int                    cycle_count = 0;
	logic [COLOUR_W-1:0]   target_rgb;
	int                    eff_width;

	color_region_steering u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	crs_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// command sink: random back-pressure, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_pixel(input logic [23:0] rgb, input logic last);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_row3(input logic [23:0] a, input logic [23:0] b, input logic [23:0] c);
		send_pixel(a, 1'b0);
		send_pixel(b, 1'b0);
		send_pixel(c, 1'b1);
	endtask

	function automatic logic [23:0] pick_colour();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return target_rgb;
		if (roll < 70)
			return target_rgb ^ (24'd1 << $urandom_range(23));
		return 24'($urandom);
	endfunction

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++)
			send_pixel(pick_colour(), i == len - 1);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
		if (idx == CFG_TARGET_COLOUR)
			target_rgb = value;
		if (idx == CFG_FRAME_WIDTH) begin
			eff_width = int'(value[FW_W-1:0]);
			if (eff_width < 3)
				eff_width = 3;
			else if (eff_width > 4096)
				eff_width = 4096;
		end
	endtask

	// wait for the last command, then let trailing pixels drain out of the pipe
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic shuffle_config(input bit every);
		logic [CFG_DATA_W-1:0] noise;
		logic [FW_W-1:0]       w13;
		logic [HIT_W-1:0]      lim;
		logic [SPEED_W-1:0]    q412;
		int                    roll;
		noise = CFG_DATA_W'($urandom);
		if (every || $urandom_range(99) < 60) begin
			roll = $urandom_range(99);
			if (roll < 70)
				w13 = FW_W'($urandom_range(12));
			else if (roll < 90)
				w13 = FW_W'($urandom_range(48, 13));
			else
				w13 = $urandom_range(1) ? 13'd4096 : 13'h1FFF;
			write_reg(CFG_FRAME_WIDTH, {noise[CFG_DATA_W-1:FW_W], w13});
		end
		if (every || $urandom_range(99) < 60) begin
			roll = $urandom_range(99);
			if (roll < 10)
				write_reg(CFG_TARGET_COLOUR, 24'h000000);
			else if (roll < 20)
				write_reg(CFG_TARGET_COLOUR, 24'hFFFFFF);
			else
				write_reg(CFG_TARGET_COLOUR, 24'($urandom));
		end
		if (every || $urandom_range(99) < 60) begin
			roll = $urandom_range(99);
			if (roll < 70)
				lim = HIT_W'($urandom_range(3));
			else if (roll < 85)
				lim = HIT_W'($urandom);
			else
				case ($urandom_range(2))
					0: lim = '0;
					1: lim = 23'h400000;
					default: lim = '1;
				endcase
			write_reg(CFG_LOW_LIMIT, {noise[CFG_DATA_W-1], lim});
		end
		if (every || $urandom_range(99) < 60) begin
			roll = $urandom_range(99);
			if (roll < 70)
				lim = HIT_W'($urandom_range(40, 2));
			else if (roll < 85)
				lim = '1;
			else
				lim = '0;
			write_reg(CFG_HIGH_LIMIT, {noise[CFG_DATA_W-2], lim});
		end
		if (every || $urandom_range(99) < 60) begin
			roll = $urandom_range(99);
			q412 = (roll < 10) ? '0 : (roll < 20) ? '1 : SPEED_W'($urandom);
			write_reg(CFG_FORWARD_SPEED, {noise[CFG_DATA_W-1:SPEED_W], q412});
		end
		if (every || $urandom_range(99) < 60) begin
			roll = $urandom_range(99);
			q412 = (roll < 10) ? '0 : (roll < 20) ? '1 : SPEED_W'($urandom);
			write_reg(CFG_TURN_RATE, {noise[CFG_DATA_W-1:SPEED_W], q412});
		end
		if ($urandom_range(99) < 15)
			write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
	endtask

	initial begin
		int          sent;
		int          len;
		logic [23:0] hit;
		logic [23:0] other;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		target_rgb = RST_TARGET_COLOUR;
		eff_width  = RST_FRAME_WIDTH;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// too few matches straight after reset: stop equals the reset pair, nothing out
		send_row3(24'hFFFF00, 24'h000000, 24'hFFFFFF);
		settle();

		write_reg(CFG_FRAME_WIDTH, 24'd3);
		write_reg(CFG_TARGET_COLOUR, 24'h000000);
		write_reg(CFG_LOW_LIMIT, 24'd0);
		write_reg(CFG_HIGH_LIMIT, 24'd4);
		write_reg(CFG_FORWARD_SPEED, 24'h007FFF);
		write_reg(CFG_TURN_RATE, 24'h007FFF);
		write_reg(CFG_SPARE_A, 24'hFFFFFF);
		write_reg(CFG_SPARE_B, 24'h000001);
		hit = 24'h000000;
		send_row3(hit, 24'h000001, 24'h800000);   // left
		send_row3(24'hFFFFFF, hit, 24'h000001);   // ahead
		send_row3(24'h800000, 24'hFFFFFF, hit);   // right, hit on the frame-end pixel
		send_row3(hit, hit, 24'h000001);          // left/middle tie goes left
		send_row3(24'hFFFFFF, hit, hit);          // middle/right tie goes ahead
		for (int i = 0; i < 6; i++)
			send_pixel(hit, i == 5);              // above high limit: stop
		settle();
		write_reg(CFG_FORWARD_SPEED, 24'd0);
		send_row3(24'h000001, hit, 24'h000001);   // ahead at zero speed, same pair as stop
		settle();

		for (int p = 0; p < PHASES; p++) begin
			settle();
			shuffle_config(p == 0);
			steady = (p == 3);
			sent = 0;
			while (sent < PHASE_PIXELS) begin
				len = $urandom_range((3 * eff_width > 40) ? 40 : 3 * eff_width, 1);
				send_frame(len);
				sent += len;
			end
			// sometimes leave a row open so the next width applies mid-row
			if ($urandom_range(1)) begin
				len = $urandom_range(5, 1);
				for (int i = 0; i < len; i++)
					send_pixel(pick_colour(), 1'b0);
			end
		end
		steady = 1'b0;

		// commands pile up behind a stalled sink and back up the pixel input
		settle();
		write_reg(CFG_FRAME_WIDTH, 24'd3);
		write_reg(CFG_LOW_LIMIT, 24'd0);
		write_reg(CFG_HIGH_LIMIT, 24'h7FFFFF);
		write_reg(CFG_FORWARD_SPEED, 24'($urandom_range(32767, 1)));
		write_reg(CFG_TURN_RATE, 24'($urandom_range(32767, 1)));
		other = ~target_rgb;
		hold_req = 1'b1;
		for (int f = 0; f < 40; f++) begin
			if (f % 2 == 0)
				send_row3(target_rgb, other, other);
			else
				send_row3(other, other, target_rgb);
		end

		// widest rows, width at or above the cap
		settle();
		write_reg(CFG_FRAME_WIDTH, $urandom_range(1) ? 24'd4096 : 24'h001FFF);
		write_reg(CFG_TARGET_COLOUR, 24'($urandom));
		write_reg(CFG_LOW_LIMIT, 24'd0);
		write_reg(CFG_HIGH_LIMIT, 24'h7FFFFF);
		send_frame($urandom_range(80, 60));
		send_frame($urandom_range(80, 60));

		settle();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
